FILE: rtl/mwf_pkg.sv
// shared types, codes and helper functions of the maze wall follower
package mwf_pkg;

  // default grid size
  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;

  // stream and configuration widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int POS_W      = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL = 1'b1;

  // request kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  // heading codes
  localparam logic [2:0] HEAD_NONE  = 3'd0;
  localparam logic [2:0] HEAD_NORTH = 3'd1;
  localparam logic [2:0] HEAD_EAST  = 3'd2;
  localparam logic [2:0] HEAD_SOUTH = 3'd3;
  localparam logic [2:0] HEAD_WEST  = 3'd4;

  // cell contents: bit 0 wall, bit 1 visited
  localparam logic [1:0] CELL_OPEN = 2'b00;
  localparam logic [1:0] CELL_WALL = 2'b01;
  localparam logic [1:0] CELL_SEEN = 2'b10;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CELL_WAIT,
    ST_CAND,
    ST_EVAL,
    ST_MARK_NEW,
    ST_FINISH
  } mwf_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic clr_write;
    logic load_write;
    logic cell_read;
    logic read_outside;
    logic cell_capture;
    logic mark_cur;
    logic cand_read;
    logic cand_next;
    logic cand_take;
    logic turn;
    logic mark_new;
    logic out_load;
  } mwf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       item_inside;
    logic       at_goal;
    logic       cand_more;
    logic       cand_inside;
    logic       cand_open;
    logic       clr_last;
    logic       out_free;
  } mwf_stat_t;

  // a real heading is north, east, south or west
  function automatic logic head_valid(input logic [2:0] d);
    return (d == HEAD_NORTH) || (d == HEAD_EAST) || (d == HEAD_SOUTH) || (d == HEAD_WEST);
  endfunction

  // number of directions tried: right, forward, left, or only west without heading
  function automatic logic [1:0] cand_count(input logic [2:0] d);
    return head_valid(d) ? 2'd3 : 2'd1;
  endfunction

  // direction of try number idx
  function automatic logic [2:0] cand_dir(input logic [2:0] d, input logic [1:0] idx);
    logic [2:0] res;
    res = HEAD_WEST;
    if (head_valid(d)) begin
      case (idx)
        2'd0:    res = (d == HEAD_WEST) ? HEAD_NORTH : d + 3'd1;
        2'd1:    res = d;
        default: res = (d == HEAD_NORTH) ? HEAD_WEST : d - 3'd1;
      endcase
    end
    return res;
  endfunction

  // heading after a turn in place
  function automatic logic [2:0] turn_dir(input logic [2:0] d);
    logic [2:0] res;
    res = HEAD_SOUTH;
    case (d)
      HEAD_NORTH: res = HEAD_SOUTH;
      HEAD_EAST:  res = HEAD_WEST;
      HEAD_SOUTH: res = HEAD_NORTH;
      HEAD_WEST:  res = HEAD_EAST;
      default:    res = HEAD_SOUTH;
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/mwf_ram.sv
// generic single-port ram with registered read
module mwf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/mwf_ctrl.sv
// sequencing state machine of the maze wall follower
module mwf_ctrl import mwf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  mwf_stat_t stat,
  output mwf_cmd_t  cmd
);

  mwf_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_FINISH;
        case (stat.kind)
          KIND_LOAD: cmd.load_write = stat.item_inside;
          KIND_READ: begin
            if (stat.item_inside) begin
              cmd.cell_read = 1'b1;
              state_next    = ST_CELL_WAIT;
            end else begin
              cmd.read_outside = 1'b1;
            end
          end
          KIND_STEP: begin
            if (!stat.at_goal) begin
              cmd.mark_cur = 1'b1;
              state_next   = ST_CAND;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_CELL_WAIT: begin
        cmd.cell_capture = 1'b1;
        state_next       = ST_FINISH;
      end
      ST_CAND: begin
        // try the next direction, skipping reads off the grid
        if (!stat.cand_more) begin
          cmd.turn   = 1'b1;
          state_next = ST_FINISH;
        end else if (stat.cand_inside) begin
          cmd.cand_read = 1'b1;
          state_next    = ST_EVAL;
        end else begin
          cmd.cand_next = 1'b1;
        end
      end
      ST_EVAL: begin
        if (stat.cand_open) begin
          cmd.cand_take = 1'b1;
          state_next    = ST_MARK_NEW;
        end else begin
          cmd.cand_next = 1'b1;
          state_next    = ST_CAND;
        end
      end
      ST_MARK_NEW: begin
        cmd.mark_new = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: rtl/mwf_dp.sv
// datapath: walker position, heading, goal, ram port select and result register
module mwf_dp import mwf_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF,
  localparam int CELLS = GRID_ROWS * GRID_COLS,
  localparam int AW = $clog2(CELLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  m_tready,
  input  mwf_cmd_t              cmd,
  output mwf_stat_t             stat,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_addr,
  output logic [1:0]            ram_wdata,
  input  logic [1:0]            ram_rdata,
  output logic                  m_tvalid,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int RW  = $clog2(GRID_ROWS);
  localparam int CW  = $clog2(GRID_COLS);
  localparam int RXW = ((RW > POS_W) ? RW : POS_W) + 1;
  localparam int CXW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [POS_W-1:0] goal_row, goal_col;
  logic [RW-1:0]    pos_row;
  logic [CW-1:0]    pos_col;
  logic [2:0]       dir;
  logic [1:0]       cand_idx;
  logic [AW-1:0]    clr_cnt;

  logic [1:0]       item_kind;
  logic [POS_W-1:0] item_row, item_col;
  logic             item_wall;
  logic             moved_r, wall_r, seen_r;

  logic             out_valid;
  logic [POS_W-1:0] out_row, out_col;
  logic [2:0]       out_head;
  logic             out_moved, out_arrived, out_wall, out_seen;

  logic [2:0]       cdir;
  logic [RW-1:0]    n_row;
  logic [CW-1:0]    n_col;
  logic             n_inside;
  logic             item_inside, at_goal;
  logic [RW-1:0]    sel_row;
  logic [CW-1:0]    sel_col;

  // goal registers
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_row <= '0;
      goal_col <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GOAL_ROW: goal_row <= cfg_data;
        CFG_GOAL_COL: goal_col <= cfg_data;
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_kind <= s_tuser;
      item_row  <= s_tdata[4:0];
      item_col  <= s_tdata[9:5];
      item_wall <= s_tdata[10];
    end
  end

  assign item_inside = (RXW'(item_row) < RXW'(GRID_ROWS)) &&
                       (CXW'(item_col) < CXW'(GRID_COLS));
  assign at_goal     = (RXW'(pos_row) == RXW'(goal_row)) &&
                       (CXW'(pos_col) == CXW'(goal_col));

  // neighbor in the direction under test
  assign cdir = cand_dir(dir, cand_idx);
  always_comb begin
    n_row    = pos_row;
    n_col    = pos_col;
    n_inside = 1'b0;
    case (cdir)
      HEAD_NORTH: begin
        n_row    = pos_row - RW'(1);
        n_inside = (pos_row != '0);
      end
      HEAD_EAST: begin
        n_col    = pos_col + CW'(1);
        n_inside = (pos_col != CW'(GRID_COLS - 1));
      end
      HEAD_SOUTH: begin
        n_row    = pos_row + RW'(1);
        n_inside = (pos_row != RW'(GRID_ROWS - 1));
      end
      HEAD_WEST: begin
        n_col    = pos_col - CW'(1);
        n_inside = (pos_col != '0);
      end
      default: n_inside = 1'b0;
    endcase
  end

  // ram port select
  always_comb begin
    sel_row   = pos_row;
    sel_col   = pos_col;
    ram_we    = 1'b0;
    ram_wdata = CELL_SEEN;
    if (cmd.load_write || cmd.cell_read) begin
      sel_row = RW'(item_row);
      sel_col = CW'(item_col);
    end else if (cmd.cand_read) begin
      sel_row = n_row;
      sel_col = n_col;
    end
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_wdata = CELL_OPEN;
    end else if (cmd.load_write) begin
      ram_we    = 1'b1;
      ram_wdata = item_wall ? CELL_WALL : CELL_OPEN;
    end else if (cmd.mark_cur || cmd.mark_new) begin
      ram_we    = 1'b1;
    end
    ram_addr = cmd.clr_write ? clr_cnt : AW'(sel_row) * AW'(GRID_COLS) + AW'(sel_col);
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // walker position and heading
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_row <= '0;
      pos_col <= '0;
      dir     <= HEAD_NONE;
    end else if (cmd.cand_take) begin
      pos_row <= n_row;
      pos_col <= n_col;
      dir     <= cdir;
    end else if (cmd.turn) begin
      dir     <= turn_dir(dir);
    end
  end

  // try counter
  always_ff @(posedge clk) begin
    if (cmd.mark_cur) begin
      cand_idx <= 2'd0;
    end else if (cmd.cand_next) begin
      cand_idx <= cand_idx + 2'd1;
    end
  end

  // per-request result flags
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      moved_r <= 1'b0;
      wall_r  <= 1'b0;
      seen_r  <= 1'b0;
    end else begin
      if (cmd.cand_take) begin
        moved_r <= 1'b1;
      end
      if (cmd.read_outside) begin
        wall_r <= 1'b1;
      end
      if (cmd.cell_capture) begin
        wall_r <= ram_rdata[0];
        seen_r <= ram_rdata[1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row     <= POS_W'(pos_row);
      out_col     <= POS_W'(pos_col);
      out_head    <= dir;
      out_moved   <= moved_r;
      out_arrived <= at_goal;
      out_wall    <= wall_r;
      out_seen    <= seen_r;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_seen, out_wall, out_arrived, out_moved,
                     out_head, out_col, out_row};

  // status to the controller
  always_comb begin
    stat.kind        = item_kind;
    stat.item_inside = item_inside;
    stat.at_goal     = at_goal;
    stat.cand_more   = (cand_idx < cand_count(dir));
    stat.cand_inside = n_inside;
    stat.cand_open   = !ram_rdata[0];
    stat.clr_last    = (clr_cnt == AW'(CELLS - 1));
    stat.out_free    = !out_valid || m_tready;
  end

endmodule

FILE: rtl/maze_wall_follower_unit.sv
// top level of the maze wall follower: controller, datapath and grid ram
// Right-hand wall follower over a GRID_ROWS x GRID_COLS grid of cells, each holding a wall
// bit and a visited bit in one single-port ram with registered read. A request is a cell
// load, a cell read or one walking step; every request gives exactly one result. After
// reset the block sweeps the ram to all open and unvisited, one cell a cycle, and takes
// no request meanwhile; goal writes on the configuration port are taken at any time.
// Requests are handled one at a time, in steps set by the single ram port and its
// registered read: a step off the goal is accepted, marks the current cell, reads and
// then evaluates each neighbor (skipping one that lies off the grid), then marks the new
// cell, or turns in place when every try is blocked, and hands the result to the output
// register. The next request is accepted while the last result still waits there; a
// result still waiting when the next one is ready holds the block in its finish state.
module maze_wall_follower_unit import mwf_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // cell_row[4:0], cell_col[9:5], wall_in[10], zeros
  input  logic [IN_USER_W-1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // walker_row[4:0], walker_col[9:5], heading[12:10],
                                           // moved[13], arrived[14], wall_out[15],
                                           // visited_out[16], zeros
);

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);

  mwf_cmd_t      cmd;
  mwf_stat_t     stat;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [1:0]    ram_wdata, ram_rdata;

  mwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mwf_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

  mwf_ram #(
    .WIDTH (2),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

FILE: rtl/mwf_checker.sv
// port-level assertions of the maze wall follower, bound to the top level
module mwf_checker import mwf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // reset starts the clearing sweep with no result pending
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block ready or result pending right after reset");

  // one request at a time: busy the cycle after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while the previous one is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind maze_wall_follower_unit mwf_checker u_chk (.*);
